### rtl/svl_pkg.sv
package svl_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_CHANNELS    = 8;
    localparam int DEF_LENGTH_BITS = 20;

    // Reset value of the chunk size register
    localparam logic [15:0] CHUNK_RESET = 16'd2048;

    // Item kinds on the input side and result kinds on the output side
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // One accepted input beat
    typedef struct packed {
        logic        kind;
        logic [7:0]  sound_id;
        logic [19:0] sound_length;
        logic [31:0] start_time;
    } svl_item_t;

    // One result beat, without the frame marker
    typedef struct packed {
        logic        kind;
        logic [2:0]  channel;
        logic [7:0]  sound;
        logic [19:0] offset;
        logic [15:0] length;
        logic        done;
    } svl_result_t;

endpackage

### rtl/sound_voice_allocator.sv
// Voice allocator for sample playback. A start beat (tuser 0) frees a channel
// already playing the same sound, takes the lowest free channel or else steals
// the one with the oldest start time, and answers with one beat naming that
// channel. A tick beat (tuser 1) answers with one read chunk per active channel
// in index order, tlast on the final one, and nothing if no channel plays.
// Channel records live in a single-port-read memory, so a start scans them
// (one entry read per cycle to find a duplicate and the oldest channel, then
// the commit), and a tick reads and writes back each active channel in turn;
// back-pressure on the output holds a tick chunk or the commit of a start.
// The next beat is taken once the last result of the current one is in the
// output register. chunk_size is to be written through the cfg channel by
// the user only while the block is idle (left unchecked); it resets to 2048.
module sound_voice_allocator
    import svl_pkg::*;
#(
    parameter int CHANNELS    = DEF_CHANNELS,
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: chunk_size
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // sound_id, sound_length, start_time
    input  logic        s_axis_tuser,  // kind
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // channel_index, chunk_sound, chunk_offset,
                                       // chunk_length, channel_done
    output logic        m_axis_tuser,  // result_kind
    output logic        m_axis_tlast   // last
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int REC_W = 8 + 2 * LENGTH_BITS + 32;

    logic [15:0]      chunk_size_reg;
    svl_item_t        in_item;
    svl_result_t      out_result;
    logic             out_last;
    logic [IDX_W-1:0] rd_addr;
    logic [REC_W-1:0] rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [REC_W-1:0] wr_data;

    // Chunk size register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_size_reg <= CHUNK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            chunk_size_reg <= cfg_data;
        end
    end

    // Unpack the input beat
    assign in_item.kind         = s_axis_tuser;
    assign in_item.sound_id     = s_axis_tdata[7:0];
    assign in_item.sound_length = s_axis_tdata[27:8];
    assign in_item.start_time   = s_axis_tdata[59:28];

    svl_seq #(
        .CHANNELS    (CHANNELS),
        .LENGTH_BITS (LENGTH_BITS),
        .IDX_W       (IDX_W),
        .REC_W       (REC_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .chunk_size (chunk_size_reg),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result),
        .out_last   (out_last)
    );

    svl_voice_ram #(
        .DEPTH  (CHANNELS),
        .WIDTH  (REC_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Pack the result beat
    assign m_axis_tdata = {out_result.done, out_result.length, out_result.offset,
                           out_result.sound, out_result.channel};
    assign m_axis_tuser = out_result.kind;
    assign m_axis_tlast = out_last;

endmodule

### rtl/svl_voice_ram.sv
module svl_voice_ram
    import svl_pkg::*;
#(
    parameter int DEPTH  = DEF_CHANNELS,
    parameter int WIDTH  = 8 + 2 * DEF_LENGTH_BITS + 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/svl_seq.sv
module svl_seq
    import svl_pkg::*;
#(
    parameter int CHANNELS    = DEF_CHANNELS,
    parameter int LENGTH_BITS = DEF_LENGTH_BITS,
    parameter int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    parameter int REC_W       = 8 + 2 * LENGTH_BITS + 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    // input beats
    input  logic              in_valid,
    output logic              in_ready,
    input  svl_item_t         in_item,
    // configuration
    input  logic [15:0]       chunk_size,
    // voice record memory
    output logic [IDX_W-1:0]  rd_addr,
    input  logic [REC_W-1:0]  rd_data,
    output logic              wr_en,
    output logic [IDX_W-1:0]  wr_addr,
    output logic [REC_W-1:0]  wr_data,
    // result beats
    output logic              out_valid,
    input  logic              out_ready,
    output svl_result_t       out_result,
    output logic              out_last
);

    localparam int LB   = LENGTH_BITS;
    localparam int CW   = (LB > 16) ? LB : 16;
    localparam int XW   = (LB > 20) ? LB : 20;
    localparam int ST_W = 2;

    localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
    localparam logic [ST_W-1:0] ST_TRUN  = 2'd1;
    localparam logic [ST_W-1:0] ST_SSCAN = 2'd2;
    localparam logic [ST_W-1:0] ST_SDONE = 2'd3;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

    // Record layout, from the top: sound, length, position, age
    localparam int AGE_LO = 0;
    localparam int POS_LO = 32;
    localparam int LEN_LO = 32 + LB;
    localparam int SND_LO = 32 + 2 * LB;

    logic [ST_W-1:0]     state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CHANNELS-1:0] active_reg, active_next;
    logic [7:0]          snd_reg, snd_next;
    logic [LB-1:0]       len_reg, len_next;
    logic [31:0]         time_reg, time_next;
    logic                dup_found_reg, dup_found_next;
    logic [IDX_W-1:0]    dup_idx_reg, dup_idx_next;
    logic [31:0]         min_age_reg, min_age_next;
    logic [IDX_W-1:0]    min_idx_reg, min_idx_next;
    logic                out_valid_reg, out_valid_next;
    svl_result_t         out_res_reg, out_res_next;
    logic                out_last_reg, out_last_next;

    logic [7:0]          rec_sound;
    logic [LB-1:0]       rec_len;
    logic [LB-1:0]       rec_pos;
    logic [31:0]         rec_age;
    logic [LB-1:0]       left;
    logic [CW-1:0]       take;
    logic [LB-1:0]       new_pos;
    logic                done;
    logic                slot_free;
    logic                first_found;
    logic [IDX_W-1:0]    first_idx;
    logic                nxt_found;
    logic [IDX_W-1:0]    nxt_idx;
    logic [CHANNELS-1:0] act_after;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic [IDX_W-1:0]    pick;
    logic                load;

    // Split the record read back from memory
    assign rec_sound = rd_data[SND_LO +: 8];
    assign rec_len   = rd_data[LEN_LO +: LB];
    assign rec_pos   = rd_data[POS_LO +: LB];
    assign rec_age   = rd_data[AGE_LO +: 32];

    // Chunk arithmetic for the channel being read
    always_comb
    begin
        left = (rec_len >= rec_pos) ? rec_len - rec_pos : '0;
        if (CW'(left) < CW'(chunk_size))
        begin
            take = CW'(left);
        end
        else
        begin
            take = CW'(chunk_size);
        end
        new_pos = rec_pos + take[LB-1:0];
        done    = (new_pos >= rec_len);
    end

    // Find the first active channel, and the next one above the current index
    always_comb
    begin
        first_found = 1'b0;
        first_idx   = '0;
        nxt_found   = 1'b0;
        nxt_idx     = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (active_reg[i])
            begin
                first_found = 1'b1;
                first_idx   = IDX_W'(i);
                if (i > int'(idx_reg))
                begin
                    nxt_found = 1'b1;
                    nxt_idx   = IDX_W'(i);
                end
            end
        end
    end

    // Lowest free channel once a duplicate has been released
    always_comb
    begin
        act_after = active_reg;
        if (dup_found_reg)
        begin
            act_after[dup_idx_reg] = 1'b0;
        end
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (!act_after[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
        pick = free_found ? free_idx : min_idx_reg;
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        active_next    = active_reg;
        snd_next       = snd_reg;
        len_next       = len_reg;
        time_next      = time_reg;
        dup_found_next = dup_found_reg;
        dup_idx_next   = dup_idx_reg;
        min_age_next   = min_age_reg;
        min_idx_next   = min_idx_reg;
        out_res_next   = out_res_reg;
        out_last_next  = out_last_reg;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data;
        load           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    snd_next  = in_item.sound_id;
                    len_next  = LB'(in_item.sound_length);
                    time_next = in_item.start_time;
                    if (in_item.kind == KIND_TICK)
                    begin
                        // a tick with nothing playing gives no result
                        if (first_found)
                        begin
                            idx_next   = first_idx;
                            rd_addr    = first_idx;
                            state_next = ST_TRUN;
                        end
                    end
                    else
                    begin
                        idx_next       = '0;
                        rd_addr        = '0;
                        dup_found_next = 1'b0;
                        state_next     = ST_SSCAN;
                    end
                end
            end

            ST_TRUN:
            begin
                if (slot_free)
                begin
                    // write back the advanced position and emit the chunk
                    wr_en                      = 1'b1;
                    wr_data[POS_LO +: LB]      = new_pos;
                    if (done)
                    begin
                        active_next[idx_reg] = 1'b0;
                    end
                    load                 = 1'b1;
                    out_res_next.kind    = KIND_TICK;
                    out_res_next.channel = 3'(idx_reg);
                    out_res_next.sound   = rec_sound;
                    out_res_next.offset  = 20'(XW'(rec_pos));
                    out_res_next.length  = take[15:0];
                    out_res_next.done    = done;
                    out_last_next        = !nxt_found;
                    if (nxt_found)
                    begin
                        idx_next = nxt_idx;
                        rd_addr  = nxt_idx;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SSCAN:
            begin
                // first active channel with the same sound
                if (active_reg[idx_reg] && rec_sound == snd_reg && !dup_found_reg)
                begin
                    dup_found_next = 1'b1;
                    dup_idx_next   = idx_reg;
                end
                // oldest start time, lowest index on ties
                if (idx_reg == '0 || rec_age < min_age_reg)
                begin
                    min_age_next = rec_age;
                    min_idx_next = idx_reg;
                end
                if (idx_reg == IDX_LAST)
                begin
                    state_next = ST_SDONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
            end

            ST_SDONE:
            begin
                if (slot_free)
                begin
                    wr_en                 = 1'b1;
                    wr_addr               = pick;
                    wr_data               = '0;
                    wr_data[SND_LO +: 8]  = snd_reg;
                    wr_data[LEN_LO +: LB] = len_reg;
                    wr_data[AGE_LO +: 32] = time_reg;
                    active_next           = act_after;
                    active_next[pick]     = 1'b1;
                    load                  = 1'b1;
                    out_res_next.kind     = KIND_START;
                    out_res_next.channel  = 3'(pick);
                    out_res_next.sound    = snd_reg;
                    out_res_next.offset   = '0;
                    out_res_next.length   = '0;
                    out_res_next.done     = 1'b0;
                    out_last_next         = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = load ? 1'b1 : (out_valid_reg && !out_ready);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        snd_reg       <= snd_next;
        len_reg       <= len_next;
        time_reg      <= time_next;
        dup_found_reg <= dup_found_next;
        dup_idx_reg   <= dup_idx_next;
        min_age_reg   <= min_age_next;
        min_idx_reg   <= min_idx_next;
        out_res_reg   <= out_res_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_res_reg;
    assign out_last   = out_last_reg;

`ifndef SYNTH
    // A new result never lands on one that is still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // Channels only become active when a start commits
    a_rise_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SDONE) |=> ((active_reg & ~$past(active_reg)) == '0))
        else $error("channel activated outside a start");

    // A start never lowers the number of playing channels
    a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SDONE && slot_free)
        |=> ($countones(active_reg) >= $countones($past(active_reg))))
        else $error("start lost a channel");

    // The final beat of an item returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_last_next) |=> (state_reg == ST_IDLE))
        else $error("sequencer busy after final beat");

    // Read and write never meet on one entry while the read data is used
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_next != ST_IDLE) |-> (wr_addr != rd_addr))
        else $error("read-write collision");
`endif

endmodule

### tb/tb_sound_voice_allocator.sv
module tb_sound_voice_allocator;
    import svl_pkg::*;

    localparam int NCH = DEF_CHANNELS;

    // One expected result beat with its frame marker
    typedef struct {
        svl_result_t res;
        logic        last;
    } voice_beat_t;

    // One row of the directed stimulus: a chunk_size write or an input beat
    typedef struct {
        bit          is_cfg;
        logic [15:0] cfg_val;
        svl_item_t   item;
        bit          typed;
        logic [2:0]  typed_ch;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // sound_id, sound_length, start_time
    logic        s_tuser = 1'b0; // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // channel_index, chunk_sound, chunk_offset,
                                 // chunk_length, channel_done
    logic        m_tuser;        // result_kind
    logic        m_tlast;        // last

    // Shadow channel table and chunk size
    bit          voice_on [NCH];
    logic [7:0]  voice_snd [NCH];
    logic [19:0] voice_len [NCH];
    logic [19:0] voice_pos [NCH];
    logic [31:0] voice_age [NCH];
    logic [15:0] chunk_bytes = CHUNK_RESET;

    voice_beat_t pending_beats [$];
    dir_row_t    dir_tab [$];
    int          mismatches = 0;
    bit          calm = 1'b0;
    bit          squeeze = 1'b0;

    sound_voice_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard limit on the run
    initial
    begin
        #3000000;
        $display("tb_sound_voice_allocator: FAIL");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Advance the shadow table by one accepted beat and queue its results.
    // A typed row overrides the predicted channel of a start.
    task automatic voice_step(input svl_item_t it, input bit typed, input logic [2:0] typed_ch);
        int          pick;
        int          last_ch;
        logic [31:0] left;
        logic [31:0] take;
        logic [19:0] pos;
        logic [19:0] npos;
        voice_beat_t b;
        if (it.kind == KIND_START)
        begin
            // free a channel already playing this sound
            for (int i = 0; i < NCH; i++)
            begin
                if (voice_on[i] && voice_snd[i] == it.sound_id)
                begin
                    voice_on[i] = 1'b0;
                    break;
                end
            end
            pick = -1;
            for (int i = 0; i < NCH; i++)
            begin
                if (!voice_on[i])
                begin
                    pick = i;
                    break;
                end
            end
            // steal the oldest, lowest index on ties
            if (pick < 0)
            begin
                pick = 0;
                for (int i = 1; i < NCH; i++)
                    if (voice_age[i] < voice_age[pick])
                        pick = i;
            end
            voice_on[pick]  = 1'b1;
            voice_snd[pick] = it.sound_id;
            voice_len[pick] = it.sound_length;
            voice_pos[pick] = '0;
            voice_age[pick] = it.start_time;
            b.res.kind    = KIND_START;
            b.res.channel = typed ? typed_ch : pick[2:0];
            b.res.sound   = it.sound_id;
            b.res.offset  = '0;
            b.res.length  = '0;
            b.res.done    = 1'b0;
            b.last        = 1'b1;
            pending_beats.push_back(b);
        end
        else
        begin
            last_ch = -1;
            for (int i = 0; i < NCH; i++)
                if (voice_on[i])
                    last_ch = i;
            // one read chunk per active channel, in index order
            for (int i = 0; i < NCH; i++)
            begin
                if (voice_on[i])
                begin
                    pos  = voice_pos[i];
                    left = (voice_len[i] >= pos) ? {12'd0, voice_len[i] - pos} : 32'd0;
                    take = (left < {16'd0, chunk_bytes}) ? left : {16'd0, chunk_bytes};
                    npos = pos + take[19:0];
                    voice_pos[i] = npos;
                    b.res.kind    = KIND_TICK;
                    b.res.channel = i[2:0];
                    b.res.sound   = voice_snd[i];
                    b.res.offset  = pos;
                    b.res.length  = take[15:0];
                    b.res.done    = (npos >= voice_len[i]);
                    b.last        = (i == last_ch);
                    if (b.res.done)
                        voice_on[i] = 1'b0;
                    pending_beats.push_back(b);
                end
            end
        end
    endtask

    // Offer one input beat, with an occasional gap, and predict it once taken
    task automatic offer_beat(input svl_item_t it, input bit typed, input logic [2:0] typed_ch);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, it.start_time, it.sound_length, it.sound_id};
        s_tuser  <= it.kind;
        do
            @(posedge clk);
        while (!s_tready);
        voice_step(it, typed, typed_ch);
    endtask

    // Write chunk_size once the block has drained
    task automatic write_chunk_size(input logic [15:0] v);
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        // a tick with no active channel gives no beat but still takes cycles
        repeat (2 * NCH + 4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        chunk_bytes = v;
    endtask

    function automatic dir_row_t start_row(input logic [7:0] snd, input logic [19:0] len,
                                           input logic [31:0] t, input bit typed,
                                           input logic [2:0] ch);
        dir_row_t r;
        r.is_cfg            = 1'b0;
        r.cfg_val           = '0;
        r.item.kind         = KIND_START;
        r.item.sound_id     = snd;
        r.item.sound_length = len;
        r.item.start_time   = t;
        r.typed             = typed;
        r.typed_ch          = ch;
        return r;
    endfunction

    function automatic dir_row_t tick_row();
        dir_row_t r;
        r       = start_row(8'd0, 20'd0, 32'd0, 1'b0, 3'd0);
        r.item.kind = KIND_TICK;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [15:0] v);
        dir_row_t r;
        r         = start_row(8'd0, 20'd0, 32'd0, 1'b0, 3'd0);
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    // Receiver: random stalls, one long hold-off to back the block up
    initial
    begin
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (squeeze && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        voice_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_beats.size() == 0)
                flag_mismatch($sformatf("unexpected beat tdata=%h tuser=%b", m_tdata, m_tuser));
            else
            begin
                want = pending_beats.pop_front();
                if (m_tuser !== want.res.kind)
                    flag_mismatch($sformatf("result_kind %b, want %b", m_tuser, want.res.kind));
                if (m_tdata[2:0] !== want.res.channel)
                    flag_mismatch($sformatf("channel %0d, want %0d",
                                            m_tdata[2:0], want.res.channel));
                if (m_tdata[10:3] !== want.res.sound)
                    flag_mismatch($sformatf("sound %h, want %h", m_tdata[10:3], want.res.sound));
                if (m_tdata[30:11] !== want.res.offset)
                    flag_mismatch($sformatf("offset %0d, want %0d",
                                            m_tdata[30:11], want.res.offset));
                if (m_tdata[46:31] !== want.res.length)
                    flag_mismatch($sformatf("length %0d, want %0d",
                                            m_tdata[46:31], want.res.length));
                if (m_tdata[47] !== want.res.done)
                    flag_mismatch($sformatf("done %b, want %b", m_tdata[47], want.res.done));
                if (m_tlast !== want.last)
                    flag_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
            end
        end
    end

    // Stimulus
    initial
    begin
        svl_item_t   it;
        int unsigned game_tick;
        int          waited;
        logic [15:0] phase_chunk;

        // Fill every channel, re-trigger a sound, then steal with ties
        dir_tab.push_back(tick_row());
        dir_tab.push_back(start_row(8'h00, 20'd0, 32'd0, 1'b1, 3'd0));
        dir_tab.push_back(start_row(8'hFF, 20'hFFFFF, 32'hFFFFFFFF, 1'b1, 3'd1));
        dir_tab.push_back(start_row(8'h12, 20'd3000, 32'd5, 1'b1, 3'd2));
        dir_tab.push_back(start_row(8'h12, 20'd100, 32'd6, 1'b1, 3'd2));
        dir_tab.push_back(start_row(8'h20, 20'd4096, 32'd9, 1'b1, 3'd3));
        dir_tab.push_back(start_row(8'h21, 20'd2048, 32'd9, 1'b1, 3'd4));
        dir_tab.push_back(start_row(8'h22, 20'd1, 32'd9, 1'b1, 3'd5));
        dir_tab.push_back(start_row(8'h23, 20'd5000, 32'd9, 1'b1, 3'd6));
        dir_tab.push_back(start_row(8'h24, 20'd70000, 32'd9, 1'b1, 3'd7));
        dir_tab.push_back(start_row(8'h30, 20'd10, 32'd7, 1'b0, 3'd0));
        dir_tab.push_back(start_row(8'h31, 20'd10, 32'd8, 1'b0, 3'd0));
        dir_tab.push_back(start_row(8'h32, 20'd500, 32'd20, 1'b0, 3'd0));
        dir_tab.push_back(start_row(8'h33, 20'd500, 32'd20, 1'b0, 3'd0));
        dir_tab.push_back(start_row(8'h34, 20'd500, 32'd20, 1'b0, 3'd0));
        // re-trigger as a zero-length sound
        dir_tab.push_back(start_row(8'h34, 20'd0, 32'd30, 1'b1, 3'd3));
        dir_tab.push_back(tick_row());
        dir_tab.push_back(tick_row());
        dir_tab.push_back(cfg_row(16'hFFFF));
        dir_tab.push_back(tick_row());
        dir_tab.push_back(tick_row());
        // zero chunk size: nothing advances, zero-length sounds still end
        dir_tab.push_back(cfg_row(16'h0000));
        dir_tab.push_back(start_row(8'h40, 20'd7, 32'd40, 1'b0, 3'd0));
        dir_tab.push_back(start_row(8'h41, 20'd0, 32'd41, 1'b0, 3'd0));
        dir_tab.push_back(tick_row());
        dir_tab.push_back(tick_row());
        dir_tab.push_back(cfg_row(16'h0001));
        dir_tab.push_back(tick_row());
        dir_tab.push_back(tick_row());

        for (int i = 0; i < NCH; i++)
            voice_on[i] = 1'b0;

        @(posedge rst_n);
        @(posedge clk);

        // Walk the directed table
        foreach (dir_tab[r])
        begin
            if (dir_tab[r].is_cfg)
                write_chunk_size(dir_tab[r].cfg_val);
            else
                offer_beat(dir_tab[r].item, dir_tab[r].typed, dir_tab[r].typed_ch);
        end

        // Random phases, each under its own chunk size
        game_tick = 100;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: phase_chunk = 16'($urandom_range(512, 4096));
                1: phase_chunk = 16'($urandom_range(1, 65535));
                2: phase_chunk = 16'hFFFF;
                default: phase_chunk = 16'($urandom_range(1, 2048));
            endcase
            write_chunk_size(phase_chunk);
            if (ph == 1)
                squeeze = 1'b1;
            if (ph == 3)
                calm = 1'b1;
            for (int n = 0; n < 21; n++)
            begin
                game_tick += $urandom_range(0, 3);
                it.kind = ($urandom_range(0, 1) == 0) ? KIND_START : KIND_TICK;
                // a small pool of sounds makes re-triggers common
                it.sound_id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                           : 8'($urandom_range(0, 11));
                case ($urandom_range(0, 9))
                    0: it.sound_length = '0;
                    1: it.sound_length = 20'($urandom);
                    default: it.sound_length = 20'($urandom_range(0, 6000));
                endcase
                it.start_time = ($urandom_range(0, 9) == 0) ? 32'($urandom) : game_tick;
                offer_beat(it, 1'b0, 3'd0);
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then let the block settle
        waited = 0;
        while (pending_beats.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_beats.size() != 0)
            flag_mismatch($sformatf("%0d expected beats never came", pending_beats.size()));
        repeat (2 * NCH + 8) @(posedge clk);

        if (mismatches == 0)
            $display("tb_sound_voice_allocator: PASS");
        else
            $display("tb_sound_voice_allocator: FAIL");
        $finish;
    end

endmodule

### sound_voice_allocator.f
rtl/svl_pkg.sv
rtl/svl_voice_ram.sv
rtl/svl_seq.sv
rtl/sound_voice_allocator.sv
tb/tb_sound_voice_allocator.sv
